// ----- rtl/qsl_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qsl_pkg
// Shared types and constants for the quicksort engine.
// ---------------------------------------------------------------------------
package qsl_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     dropped;
  } out_item_t;

  // Command handed from the front end to the sort engine
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     store;  // write value at the next free slot
    logic                     last;   // sort and emit after this one
    logic                     ovf;    // this item was discarded
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_M_RD,
    S_M_CMP,
    S_V_RD,
    S_P_RD,
    S_P_CMP,
    S_F_RD,
    S_P_FIN,
    S_EMIT_RD,
    S_EMIT_WAIT
  } eng_state_t;

  // signed less-than
  function automatic logic lt_s(input logic signed [DATA_W-1:0] a,
                                input logic signed [DATA_W-1:0] b);
    lt_s = a < b;
  endfunction

endpackage

// ----- rtl/qsl_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qsl_front
// Accepts input items, tracks store occupancy and marks discarded items.
// ---------------------------------------------------------------------------
module qsl_front #(
  parameter int DEPTH = qsl_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  qsl_pkg::in_item_t  in_item,
  output logic               in_full,
  output logic               cmd_valid,
  output qsl_pkg::cmd_t      cmd,
  input  logic               q_full,
  input  logic               eng_idle
);
  import qsl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;  // a last item went by; wait for the engine
  logic          acc;
  logic          room;

  assign in_full = q_full | busy_r;
  assign acc     = in_push & ~in_full;
  assign room    = cnt_r < CW'(DEPTH);

  always_comb begin
    cmd.value = in_item.value;
    cmd.store = room;
    cmd.last  = in_item.last;
    cmd.ovf   = ~room;
  end
  assign cmd_valid = acc;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    // engine back in idle with nothing queued: the batch has been emitted
    if (busy_r && eng_idle) busy_nxt = 1'b0;
    if (acc) begin
      if (in_item.last) begin
        cnt_nxt  = '0;
        busy_nxt = 1'b1;
      end else if (room) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end
endmodule

// ----- rtl/qsl_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qsl_cmd_fifo
// Two-entry queue between the front end and the sort engine.
// ---------------------------------------------------------------------------
module qsl_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  qsl_pkg::cmd_t wdata,
  output logic          full,
  output logic          rvalid,
  output qsl_pkg::cmd_t rdata,
  input  logic          rd
);
  import qsl_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full   = cnt_r == 2'd2;
  assign rvalid = cnt_r != 2'd0;
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr && !full) wp_r <= ~wp_r;
      if (rd && rvalid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((wr && !full) ? 1 : 0) - 2'((rd && rvalid) ? 1 : 0);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("cmd queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (full && !rd) |=> full)
    else $error("cmd queue lost an entry");
endmodule

// ----- rtl/qsl_engine.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qsl_engine
// Stores elements, runs quicksort with Lomuto partitioning over an explicit
// range stack, then streams the sorted batch into a two-entry result queue.
// ---------------------------------------------------------------------------
module qsl_engine #(
  parameter int DEPTH = qsl_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pivot_mode,
  input  logic              cmd_valid,
  input  qsl_pkg::cmd_t     cmd,
  output logic              cmd_rd,
  output logic              out_empty,
  output qsl_pkg::out_item_t out_item,
  input  logic              out_pop,
  output logic              idle
);
  import qsl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  // ranges on the stack are disjoint and hold at least two elements each
  localparam int SD = (DEPTH > 1) ? DEPTH / 2 : 1;
  localparam int SW = $clog2(SD + 1);
  localparam int IW = (SD > 1) ? $clog2(SD) : 1;

  // memories
  logic signed [DATA_W-1:0] mem_r [DEPTH];
  logic [2*AW-1:0]          stk_r [SD];

  eng_state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [1:0]    mstep_r, mstep_nxt;     // median-of-three swap step
  logic signed [DATA_W-1:0] piv_r, piv_nxt;
  logic signed [DATA_W-1:0] ra_r, rb_r;  // registered reads
  logic [AW-1:0] rda, rdb;               // read addresses
  logic          we_a, we_b;
  logic [AW-1:0] wa_a, wa_b;
  logic signed [DATA_W-1:0] wd_a, wd_b;
  logic          spush_a, spush_b;
  logic [IW-1:0] sa_idx, sb_idx;
  logic [2*AW-1:0] spush_ad, spush_bd;
  logic [CW-1:0] k_r, k_nxt;

  // result queue
  out_item_t  oq_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       o_wr;
  out_item_t  o_wd;
  logic       o_rd;
  logic [1:0] o_pend;

  logic [AW:0] mid_sum;
  logic [AW-1:0] mid;
  logic [2*AW-1:0] top;
  logic swap_a;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[AW:1];
  assign top     = stk_r[IW'(sp_r - SW'(1))];
  assign o_rd    = out_pop & ~out_empty;
  assign out_empty = ocnt_r == 2'd0;
  assign out_item  = oq_r[orp_r];
  assign idle    = st_r == S_IDLE;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:      if (cmd_valid && cmd.last) st_nxt = (cnt_nxt < CW'(2)) ?
                     ((cnt_nxt == '0) ? S_IDLE : S_EMIT_RD) : S_POP;
      S_POP:       if (sp_r == '0) st_nxt = S_EMIT_RD;
                   else if (top[AW-1:0] > top[2*AW-1:AW]
                            && CW'(top[AW-1:0]) < cnt_r)
                     st_nxt = pivot_mode ? S_M_RD : S_V_RD;
      S_M_RD:      st_nxt = S_M_CMP;
      S_M_CMP:     st_nxt = (mstep_r == 2'd3) ? S_V_RD : S_M_RD;
      S_V_RD:      st_nxt = S_P_RD;
      S_P_RD:      st_nxt = S_P_CMP;
      S_P_CMP:     st_nxt = (i_r + AW'(1) == hi_r) ? S_F_RD : S_P_RD;
      S_F_RD:      st_nxt = S_P_FIN;
      S_P_FIN:     st_nxt = S_POP;
      S_EMIT_RD:   st_nxt = S_EMIT_WAIT;
      S_EMIT_WAIT: if (o_wr) st_nxt = (k_r + CW'(1) == cnt_r) ? S_IDLE : S_EMIT_RD;
      default:     st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r; sp_nxt = sp_r; ovf_nxt = ovf_r;
    lo_nxt = lo_r; hi_nxt = hi_r; i_nxt = i_r; j_nxt = j_r;
    mstep_nxt = mstep_r; piv_nxt = piv_r; k_nxt = k_r;
    rda = i_r; rdb = hi_r;
    we_a = 1'b0; we_b = 1'b0; wa_a = i_r; wa_b = j_r; wd_a = rb_r; wd_b = ra_r;
    spush_a = 1'b0; spush_b = 1'b0; spush_ad = '0; spush_bd = '0;
    sa_idx = IW'(sp_r); sb_idx = IW'(sp_r);
    cmd_rd = 1'b0; o_wr = 1'b0; o_wd = '0; swap_a = 1'b0;
    case (st_r)
      S_IDLE: begin
        cmd_rd = cmd_valid;
        if (cmd_valid) begin
          if (cmd.store) begin
            we_a = 1'b1; wa_a = cnt_r[AW-1:0]; wd_a = cmd.value;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (cmd.ovf) ovf_nxt = 1'b1;
          if (cmd.last) begin
            spush_a = 1'b1; sa_idx = '0;
            spush_ad = {AW'(0), AW'(cnt_nxt - CW'(1))};
            sp_nxt = SW'(1);
            k_nxt = '0;
            if (cnt_nxt < CW'(2)) sp_nxt = '0;
          end
        end
      end
      S_POP: if (sp_r != '0) begin
        sp_nxt = sp_r - SW'(1);
        lo_nxt = top[2*AW-1:AW]; hi_nxt = top[AW-1:0];
        i_nxt = top[2*AW-1:AW]; j_nxt = top[2*AW-1:AW];
        mstep_nxt = 2'd0;
      end
      S_M_RD: begin
        case (mstep_r)
          2'd0:    begin rda = mid;  rdb = lo_r; end
          2'd1:    begin rda = hi_r; rdb = lo_r; end
          2'd2:    begin rda = hi_r; rdb = mid;  end
          default: begin rda = mid;  rdb = hi_r; end
        endcase
      end
      S_M_CMP: begin
        // ra = element at first address, rb = second; swap when ra<rb,
        // and the last step swaps unconditionally
        swap_a = (mstep_r == 2'd3) | lt_s(ra_r, rb_r);
        case (mstep_r)
          2'd0:    begin wa_a = mid;  wa_b = lo_r; end
          2'd1:    begin wa_a = hi_r; wa_b = lo_r; end
          2'd2:    begin wa_a = hi_r; wa_b = mid;  end
          default: begin wa_a = mid;  wa_b = hi_r; end
        endcase
        wd_a = rb_r; wd_b = ra_r;
        we_a = swap_a; we_b = swap_a;
        mstep_nxt = mstep_r + 2'd1;
      end
      S_V_RD: begin
        rdb = hi_r;
      end
      S_P_RD: begin
        // first pass: rb still holds the pivot read in S_V_RD
        if (i_r == lo_r) piv_nxt = rb_r;
        rda = i_r; rdb = j_r;
      end
      S_P_CMP: begin
        if (!lt_s(piv_r, ra_r)) begin
          // swap elements i and j
          we_a = 1'b1; wa_a = j_r; wd_a = ra_r;
          we_b = (j_r != i_r); wa_b = i_r; wd_b = rb_r;
          j_nxt = j_r + AW'(1);
        end
        i_nxt = i_r + AW'(1);
      end
      S_F_RD: begin
        rdb = j_r;
      end
      S_P_FIN: begin
        we_a = 1'b1; wa_a = j_r; wd_a = piv_r;
        we_b = (j_r != hi_r); wa_b = hi_r; wd_b = rb_r;
        spush_a = j_r > lo_r + AW'(1);
        spush_ad = {lo_r, AW'(j_r - AW'(1))};
        spush_b = ({1'b0, j_r} + (AW+1)'(1)) < {1'b0, hi_r};
        spush_bd = {AW'(j_r + AW'(1)), hi_r};
        sa_idx = IW'(sp_r);
        sb_idx = IW'(sp_r + SW'(spush_a));
        sp_nxt = sp_r + SW'(spush_a) + SW'(spush_b);
      end
      S_EMIT_RD: begin
        rda = k_r[AW-1:0];
      end
      S_EMIT_WAIT: begin
        // keep the read on k so a stalled result stays valid
        rda = k_r[AW-1:0];
        o_wr = ocnt_r != 2'd2;
        o_wd.sorted_value = ra_r;
        o_wd.final_res = (k_r + CW'(1) == cnt_r);
        o_wd.dropped = ovf_r;
        if (o_wr) begin
          k_nxt = k_r + CW'(1);
          if (k_r + CW'(1) == cnt_r) begin
            cnt_nxt = '0; ovf_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (st_r == S_IDLE && cmd_valid && cmd.last && cnt_nxt == '0) begin
      ovf_nxt = 1'b0;
    end
  end

  // memory access
  always_ff @(posedge clk) begin
    if (we_a) mem_r[wa_a] <= wd_a;
    if (we_b) mem_r[wa_b] <= wd_b;
    ra_r <= mem_r[rda];
    rb_r <= mem_r[rdb];
  end

  always_ff @(posedge clk) begin
    if (spush_a) stk_r[sa_idx] <= spush_ad;
    if (spush_b) stk_r[sb_idx] <= spush_bd;
  end

  always_ff @(posedge clk) begin
    if (o_wr) oq_r[owp_r] <= o_wd;
  end

  assign o_pend = 2'((o_wr) ? 1 : 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; sp_r <= '0; ovf_r <= 1'b0;
      owp_r <= 1'b0; orp_r <= 1'b0; ocnt_r <= 2'd0; k_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; k_r <= k_nxt;
      sp_r <= sp_nxt;
      if (o_wr) owp_r <= ~owp_r;
      if (o_rd) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + o_pend - 2'(o_rd ? 1 : 0);
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; i_r <= i_nxt; j_r <= j_nxt;
    mstep_r <= mstep_nxt; piv_r <= piv_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) ocnt_r != 2'd3)
    else $error("result queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n) sp_r <= SW'(SD))
    else $error("range stack overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_P_CMP) |-> (j_r <= i_r))
    else $error("partition store index passed scan index");
endmodule

// ----- rtl/quicksort_lomuto_engine_core.sv -----
`timescale 1ns / 1ps
// Flow: items load at one per cycle while full is low; after the last item each
//   partition reads the pivot, scans its elements and places the pivot (after a
//   median-of-three step if enabled); results then pass a two-entry result queue.
// Throughput: one batch at a time; full stays high from the last item's transfer
//   until the last result has entered the result queue.
// Reset: synchronous active-low rst_n clears counts, queues and pivot_mode.
// ---------------------------------------------------------------------------
// quicksort_lomuto_engine_core
// Top level: front end, command queue and sort engine.
// ---------------------------------------------------------------------------
module quicksort_lomuto_engine_core #(
  parameter int DEPTH = qsl_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  qsl_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output qsl_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import qsl_pkg::*;

  logic pivot_mode_r;
  logic c_wr, c_full, c_valid, c_rd, idle;
  cmd_t c_wd, c_rdat;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) pivot_mode_r <= 1'b0;
    else if (cfg_valid) pivot_mode_r <= cfg_data;
  end

  // engine idle with an empty command queue means the batch is done
  qsl_front #(.DEPTH(DEPTH)) u_front (
    .clk, .rst_n, .in_push(push), .in_item(in_data), .in_full(full),
    .cmd_valid(c_wr), .cmd(c_wd), .q_full(c_full), .eng_idle(idle & ~c_valid)
  );

  qsl_cmd_fifo u_fifo (
    .clk, .rst_n, .wr(c_wr), .wdata(c_wd), .full(c_full),
    .rvalid(c_valid), .rdata(c_rdat), .rd(c_rd)
  );

  qsl_engine #(.DEPTH(DEPTH)) u_eng (
    .clk, .rst_n, .pivot_mode(pivot_mode_r), .cmd_valid(c_valid), .cmd(c_rdat),
    .cmd_rd(c_rd), .out_empty(empty), .out_item(out_data), .out_pop(pop),
    .idle(idle)
  );
endmodule

// ----- dv/quicksort_lomuto_engine_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quicksort_lomuto_engine_core_tb
// Loads batches of signed values, predicts the sorted stream with a local
// insertion sort, and checks every popped result against the expected queue.
// ---------------------------------------------------------------------------
module quicksort_lomuto_engine_core_tb;
  import qsl_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  class sort_scoreboard;
    logic signed [DATA_W-1:0] batch[$];
    out_item_t expected_q[$];
    bit overflow;
    int mismatches;
    int results_seen;
    int batches;

    // Store the accepted item; on last, sort the batch and queue the results.
    function void note_input(in_item_t it);
      logic signed [DATA_W-1:0] tmp;
      out_item_t r;
      if (batch.size() < DEPTH) batch.push_back(it.value);
      else overflow = 1;
      if (!it.last) return;
      // Pivot mode only changes the order of work, not the sorted output.
      for (int i = 1; i < batch.size(); i++) begin
        tmp = batch[i];
        for (int j = i; j > 0 && batch[j-1] > tmp; j--) begin
          batch[j] = batch[j-1];
          batch[j-1] = tmp;
        end
      end
      for (int k = 0; k < batch.size(); k++) begin
        r.sorted_value = batch[k];
        r.final_res = (k == batch.size() - 1);
        r.dropped = overflow;
        expected_q.push_back(r);
      end
      batch.delete();
      overflow = 0;
      batches++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.sorted_value !== exp_r.sorted_value || got.final_res !== exp_r.final_res ||
          got.dropped !== exp_r.dropped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected val=%0d fin=%0b drop=%0b, got val=%0d fin=%0b drop=%0b",
                   exp_r.sorted_value, exp_r.final_res, exp_r.dropped,
                   got.sorted_value, got.final_res, got.dropped);
      end
    endfunction
  endclass

  logic clk, rst_n, push, full, empty, pop, cfg_valid, cfg_ready, cfg_data;
  in_item_t in_data;
  out_item_t out_data;

  int send_idle_pct, recv_idle_pct;
  bit recv_hold;
  int items_sent;
  sort_scoreboard sb;

  quicksort_lomuto_engine_core #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[quicksort_lomuto_engine_core] ERROR");
    $finish;
  end

  // Receiver: random pop, plus a long hold-off when recv_hold is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 0;
    end else begin
      if (pop && !empty) sb.check_result(out_data);
      pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(7)) - 32'd3);
      default: return $signed($urandom);
    endcase
  endfunction

  // push stays high between back-to-back items; it drops while idling
  task automatic send_item(logic signed [DATA_W-1:0] v, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk);
    end
    in_data <= '{value: v, last: lst};
    push <= 1;
    do @(posedge clk); while (full);
    sb.note_input('{value: v, last: lst});
    items_sent++;
  endtask

  task automatic send_batch(int n, int dup_range);
    logic signed [DATA_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      v = (dup_range > 0) ? $signed(32'($urandom_range(dup_range))) : rand_value();
      send_item(v, i == n - 1);
    end
  endtask

  task automatic wait_drained();
    push <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_data <= m;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst_n = 0; push = 0; in_data = '0; cfg_valid = 0; cfg_data = 0;
    recv_hold = 0; send_idle_pct = 0; recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: single item, extremes, reverse and equal runs, both modes
    send_item(32'sh7fffffff, 1);
    send_batch(2, 0);
    send_item(32'sh80000000, 0); send_item(32'sh7fffffff, 0);
    send_item(0, 0); send_item(-1, 0); send_item(1, 1);
    wait_drained();
    write_mode(1);
    for (int i = 0; i < 6; i++) send_item(5 - i, i == 5);
    for (int i = 0; i < 6; i++) send_item(3, i == 5);
    wait_drained();

    // overflow batch under a long receiver stall; the next batch backs up
    fork
      begin
        recv_hold = 1;
        repeat (1500) @(posedge clk);
        recv_hold = 0;
      end
    join_none
    send_batch(DEPTH + 3, 50);
    send_batch(5, 0);
    wait_drained();
    write_mode(0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 31 : 0;
      while (items_sent < 60 + (phase + 1) * 125) begin
        case ($urandom_range(9))
          0: send_batch(DEPTH + $urandom_range(4), 0);
          1: send_batch(DEPTH, 3);
          2: send_batch(1, 0);
          default: send_batch($urandom_range(2, 20), $urandom_range(1) ? 0 : 4);
        endcase
      end
      wait_drained();
      write_mode($urandom_range(1));
    end
    write_mode(1);
    send_batch(12, 0);
    wait_drained();
    write_mode(0);
    wait_drained();
    repeat (50) @(posedge clk);

    $display("covered %0d items in %0d batches, %0d results, both pivot modes",
             items_sent, sb.batches, sb.results_seen);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("[quicksort_lomuto_engine_core] OK");
    else
      $display("[quicksort_lomuto_engine_core] ERROR");
    $finish;
  end
endmodule
